// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the core of the three-level priority queue.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define TLPQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tlpq assertion failed");
// Condition must never be seen outside reset.
`define TLPQ_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tlpq forbidden condition seen");
`else
`define TLPQ_ASSERT(lbl, clk, rst_n, prop)
`define TLPQ_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: src/tlpq_pkg.sv
// ---------------------------------------------------------------------------
// tlpq_pkg
// Codes, field widths and shared types of the three-level priority queue.
// ---------------------------------------------------------------------------
package tlpq_pkg;

    // Field widths of the command and result transactions
    localparam int KEY_FIELD_W = 16;
    localparam int LEVEL_W     = 2;
    localparam int OPCODE_W    = 2;
    localparam int STATUS_W    = 3;
    localparam int OCC_W       = 5;

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 3;

    // Command codes
    localparam logic [OPCODE_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ENQUEUED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DEQUEUED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_LEVEL = 3'd6;

    // Level code that no entry may carry
    localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd0;

    // Operation of the shared compare unit
    typedef enum logic [1:0] {
        CMP_KEY_EQ,
        CMP_LEVEL_GE,
        CMP_ALWAYS
    } cmp_mode_t;

endpackage

// File: src/three_level_priority_queue_core.sv
// ---------------------------------------------------------------------------
// three_level_priority_queue_core
// Strict three-level priority queue, arrival order kept within each level.
// ---------------------------------------------------------------------------
// The queue holds up to QUEUE_DEPTH entries (a key and a level 1..3) in a
// single-port-write, single-port-read memory kept in service order, slot 0
// being the head. Every command transaction yields exactly one result
// transaction. A command occupies the block from acceptance until its result
// is loaded into the output register; s_axis_tready is high only while the
// sequencer is idle, but a new command is taken while an earlier result still
// waits on the master side. The memory walk visits one slot at a time: a read,
// then a compare with optional write-back; the result is loaded after the
// walk. Enqueue walks from the tail down to its insertion point, or to the
// head when it goes ahead of all held entries. Dequeue and remove walk from
// the head to the tail, closing the gap as they go. Rejected commands (bad
// level, full, empty, unused code) do not walk. The store needs no clearing
// after reset; the walk never visits slots at or above the entry count.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module three_level_priority_queue_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BITS    = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // Command: tdata = user_key[15:0], priority_level[17:16], zero [23:18]
    //          tuser = opcode[1:0]
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tlpq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic [tlpq_pkg::IN_TUSER_W-1:0]    s_axis_tuser,

    // Result: tdata = out_key[15:0], out_level[17:16], occupancy[22:18],
    //                 zero [23]
    //         tuser = status[2:0]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [tlpq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [tlpq_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

    import tlpq_pkg::*;

    // Stored key width: the command key field, cut to KEY_BITS when narrower
    localparam int SKEY_W = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
    localparam int ENT_W  = SKEY_W + LEVEL_W;
    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_PLACE,
        S_FINISH
    } state_t;

    // Control state
    state_t                state_reg,  state_next;
    logic [CNT_W-1:0]      count_reg,  count_next;
    logic                  found_reg,  found_next;
    logic                  m_valid_reg, m_valid_next;

    // Command and result payload
    logic [OPCODE_W-1:0]   op_reg,     op_next;
    logic [SKEY_W-1:0]     key_reg,    key_next;
    logic [LEVEL_W-1:0]    lvl_reg,    lvl_next;
    logic [IDX_W-1:0]      idx_reg,    idx_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [KEY_FIELD_W-1:0] res_key_reg,   res_key_next;
    logic [LEVEL_W-1:0]    res_lvl_reg,    res_lvl_next;
    logic [OUT_TDATA_W-1:0] m_data_reg,    m_data_next;
    logic [OUT_TUSER_W-1:0] m_user_reg,    m_user_next;

    // Memory and compare unit hookup
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [ENT_W-1:0]      mem_wdata;
    logic [ENT_W-1:0]      mem_rdata;
    logic [SKEY_W-1:0]     ent_key;
    logic [LEVEL_W-1:0]    ent_lvl;
    cmp_mode_t             cmp_mode;
    logic                  cmp_hit;

    // Command fields as they arrive
    logic [OPCODE_W-1:0]   in_opcode;
    logic [SKEY_W-1:0]     in_key;
    logic [LEVEL_W-1:0]    in_level;

    logic                  cmd_take;
    logic                  hit_now;
    logic                  last_slot;
    logic                  out_free;

    assign in_opcode = s_axis_tuser[OPCODE_W-1:0];
    assign in_key    = s_axis_tdata[SKEY_W-1:0];
    assign in_level  = s_axis_tdata[KEY_FIELD_W +: LEVEL_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cmd_take      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign ent_key = mem_rdata[LEVEL_W +: SKEY_W];
    assign ent_lvl = mem_rdata[LEVEL_W-1:0];

    // Enqueue compares levels on its way down; remove matches keys on its
    // way up; dequeue takes whatever sits at the head.
    always_comb
    begin
        case (op_reg)
            OP_ENQUEUE: cmp_mode = CMP_LEVEL_GE;
            OP_REMOVE:  cmp_mode = CMP_KEY_EQ;
            default:    cmp_mode = CMP_ALWAYS;
        endcase
    end

    tlpq_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (ENT_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (idx_reg),
        .rd_data (mem_rdata)
    );

    tlpq_cmp #(
        .KEY_W (SKEY_W)
    ) u_cmp (
        .mode        (cmp_mode),
        .entry_key   (ent_key),
        .entry_level (ent_lvl),
        .ref_key     (key_reg),
        .ref_level   (lvl_reg),
        .hit         (cmp_hit)
    );

    assign hit_now   = !found_reg && cmp_hit;
    assign last_slot = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        lvl_next        = lvl_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_lvl_next    = res_lvl_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = mem_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    op_next         = in_opcode;
                    key_next        = in_key;
                    lvl_next        = in_level;
                    found_next      = 1'b0;
                    idx_next        = '0;
                    res_key_next    = '0;
                    res_lvl_next    = LEVEL_NONE;
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_FINISH;
                    case (in_opcode)
                        OP_ENQUEUE:
                        begin
                            if (in_level == LEVEL_NONE)
                            begin
                                res_status_next = ST_BAD_LEVEL;
                            end
                            else if (count_reg == CNT_FULL)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = S_PLACE;
                            end
                            else
                            begin
                                // Start at the tail and walk toward the head
                                idx_next   = IDX_W'(count_reg - CNT_W'(1));
                                state_next = S_READ;
                            end
                        end
                        OP_DEQUEUE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                if (op_reg == OP_ENQUEUE)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg + IDX_W'(1);
                    if (cmp_hit)
                    begin
                        // Slot holds an equal or higher level: insert behind it
                        mem_wdata       = {key_reg, lvl_reg};
                        count_next      = count_reg + CNT_W'(1);
                        res_status_next = ST_ENQUEUED;
                        state_next      = S_FINISH;
                    end
                    else if (idx_reg == '0)
                    begin
                        // Every entry moved up: new entry becomes the head
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = S_READ;
                    end
                end
                else
                begin
                    // Past the removed slot, shift each entry down by one
                    if (found_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_reg - IDX_W'(1);
                    end
                    if (hit_now)
                    begin
                        found_next      = 1'b1;
                        res_key_next    = KEY_FIELD_W'(ent_key);
                        res_lvl_next    = ent_lvl;
                        res_status_next = (op_reg == OP_DEQUEUE) ? ST_DEQUEUED
                                                                 : ST_REMOVED;
                    end
                    if (last_slot)
                    begin
                        if (found_reg || hit_now)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_READ;
                    end
                end
            end

            S_PLACE:
            begin
                mem_we          = 1'b1;
                mem_waddr       = idx_reg;
                mem_wdata       = {key_reg, lvl_reg};
                count_next      = count_reg + CNT_W'(1);
                res_status_next = ST_ENQUEUED;
                state_next      = S_FINISH;
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: load the finished result once the slot is free
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if ((state_reg == S_FINISH) && out_free)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, OCC_W'(count_reg), res_lvl_reg, res_key_reg};
            m_user_next  = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        lvl_reg        <= lvl_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_lvl_reg    <= res_lvl_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Occupancy never exceeds the store
    `TLPQ_NEVER(a_count_bound, clk, rst_n, count_reg > CNT_FULL)
    // An accepted command always leaves idle on the next cycle
    `TLPQ_ASSERT(a_take_busy, clk, rst_n, cmd_take |=> (state_reg != S_IDLE))
    // Occupancy moves by at most one, and only after a compare or placement state
    `TLPQ_ASSERT(a_count_step, clk, rst_n,
        (count_reg != $past(count_reg)) |->
            (($past(state_reg) == S_EVAL) || ($past(state_reg) == S_PLACE)))
    // Reads only visit held slots
    `TLPQ_ASSERT(a_read_range, clk, rst_n,
        (state_reg == S_READ) |-> (CNT_W'(idx_reg) < count_reg))
    // The store is written only by the walk or the final placement
    `TLPQ_ASSERT(a_write_phase, clk, rst_n,
        mem_we |-> ((state_reg == S_EVAL) || (state_reg == S_PLACE)))

endmodule

// File: src/tlpq_mem.sv
// ---------------------------------------------------------------------------
// tlpq_mem
// Entry store: one write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module tlpq_mem #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 18
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/tlpq_cmp.sv
// ---------------------------------------------------------------------------
// tlpq_cmp
// Shared compare unit: key match or level order of one stored entry.
// ---------------------------------------------------------------------------
module tlpq_cmp #(
    parameter int KEY_W = 16
) (
    input  tlpq_pkg::cmp_mode_t           mode,
    input  logic [KEY_W-1:0]              entry_key,
    input  logic [tlpq_pkg::LEVEL_W-1:0]  entry_level,
    input  logic [KEY_W-1:0]              ref_key,
    input  logic [tlpq_pkg::LEVEL_W-1:0]  ref_level,
    output logic                          hit
);

    import tlpq_pkg::*;

    always_comb
    begin
        case (mode)
            CMP_KEY_EQ:   hit = (entry_key == ref_key);
            CMP_LEVEL_GE: hit = (entry_level >= ref_level);
            CMP_ALWAYS:   hit = 1'b1;
            default:      hit = 1'b0;
        endcase
    end

endmodule
